// ===== src/lbp_pkg.sv =====
// Shared types and constants for the 3x3 local binary pattern stream block.
`default_nettype none
package lbp_pkg;

    localparam int LBP_MAX_WIDTH    = 2048;
    localparam int LBP_HEIGHT_LIMIT = 4096;
    localparam int LBP_WIDTH_RESET  = 640;
    localparam int LBP_HEIGHT_RESET = 480;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int CFG_W   = 13;
    localparam int IMG_W_W = 12;
    localparam int IMG_H_W = 13;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } lbp_col_t;

endpackage
`default_nettype wire

// ===== src/lbp_line_store.sv =====
// Two-row line store held as one memory of {top, middle} pixel pairs.
`default_nettype none
module lbp_line_store
    import lbp_pkg::*;
#(
    parameter int DEPTH = LBP_MAX_WIDTH,
    parameter int AW    = $clog2(LBP_MAX_WIDTH)
) (
    input  wire logic               aclk,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [2*PIX_W-1:0] rd_data,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [2*PIX_W-1:0] wr_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== src/lbp_win_cell.sv =====
// One column cell of the 3x3 window, passing its column on at each shift.
`default_nettype none
module lbp_win_cell
    import lbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     shift,
    input  wire lbp_col_t col_in,
    output lbp_col_t      col_out
);

    lbp_col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule
`default_nettype wire

// ===== src/lbp_3x3_stream.sv =====
// Top level of the streaming 3x3 local binary pattern block.
//
// Grey pixels enter in raster order, one item per clock unless m_ready stalls the output,
// and each interior pixel yields one 8-bit pattern code two pipeline stages later: the
// registered read of the line store, then the window shift and the code register. The
// line store is a single memory of MAX_WIDTH words read and written at most once per
// cycle, the window is a chain of column cells, and border rows and columns give no code.
// A register write restarts the frame and must be made while the block is idle.
`default_nettype none
module lbp_3x3_stream
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [PIX_W-1:0] m_lbp_code,
    output logic                  m_frame_last,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int COL_LAST_RESET =
        ((LBP_WIDTH_RESET < MAX_WIDTH) ? LBP_WIDTH_RESET : MAX_WIDTH) - 1;
    localparam int ROW_LAST_RESET = LBP_HEIGHT_RESET - 1;

    function automatic logic [PIX_W-1:0] pattern(lbp_col_t l, lbp_col_t c, lbp_col_t r);
        logic [PIX_W-1:0] code;
        code = '0;
        code[0] = l.top > c.mid;
        code[1] = l.mid > c.mid;
        code[2] = l.bot > c.mid;
        code[3] = c.bot > c.mid;
        code[4] = r.bot > c.mid;
        code[5] = r.mid > c.mid;
        code[6] = r.top > c.mid;
        code[7] = c.top > c.mid;
        return code;
    endfunction

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;

    logic             v1_reg, v1_next;
    logic [PIX_W-1:0] px1_reg;
    logic [CW-1:0]    addr1_reg;
    logic             emit1_reg;
    logic             last1_reg;

    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] code_reg;
    logic             last_reg;

    logic               adv;
    logic               s_acc;
    logic               s1_move;
    logic [2*PIX_W-1:0] rd_data;
    lbp_col_t           new_col;
    lbp_col_t           col_a;
    lbp_col_t           col_b;
    int unsigned        w_eff;
    int unsigned        h_eff;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !v1_reg || adv;
    assign s_acc   = s_valid && s_ready;
    assign s1_move = v1_reg && adv;

    lbp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_move),
        .wr_addr (addr1_reg),
        .wr_data ({rd_data[PIX_W-1:0], px1_reg})
    );

    assign new_col.top = rd_data[2*PIX_W-1:PIX_W];
    assign new_col.mid = rd_data[PIX_W-1:0];
    assign new_col.bot = px1_reg;

    lbp_win_cell u_cell_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (s1_move),
        .col_in  (new_col),
        .col_out (col_a)
    );

    lbp_win_cell u_cell_centre (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (s1_move),
        .col_in  (col_a),
        .col_out (col_b)
    );

    always_comb begin
        w_eff = 32'(cfg_wdata[IMG_W_W-1:0]);
        if (w_eff < 3) begin
            w_eff = 3;
        end
        if (w_eff > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end
        h_eff = 32'(cfg_wdata[IMG_H_W-1:0]);
        if (h_eff < 3) begin
            h_eff = 3;
        end
        if (h_eff > 32'(LBP_HEIGHT_LIMIT)) begin
            h_eff = 32'(LBP_HEIGHT_LIMIT);
        end
    end

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    col_last_next = CW'(w_eff - 1);
                end
                REG_IMAGE_HEIGHT: begin
                    row_last_next = ROW_W'(h_eff - 1);
                end
                default: begin
                    col_last_next = col_last_reg;
                end
            endcase
        end else if (s_acc) begin
            if (col_reg == col_last_reg) begin
                col_next = '0;
                if (row_reg == row_last_reg) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (s_acc) begin
            v1_next = 1'b1;
        end else if (s1_move) begin
            v1_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = v1_reg && emit1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            col_last_reg <= CW'(COL_LAST_RESET);
            row_last_reg <= ROW_W'(ROW_LAST_RESET);
            v1_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            v1_reg       <= v1_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            px1_reg   <= s_pixel;
            addr1_reg <= col_reg;
            emit1_reg <= (|row_reg[ROW_W-1:1]) && (|col_reg[CW-1:1]);
            last1_reg <= (row_reg == row_last_reg) && (col_reg == col_last_reg);
        end
        if (s1_move) begin
            code_reg <= pattern(col_b, col_a, new_col);
            last_reg <= last1_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lbp_code   = code_reg;
    assign m_frame_last = last_reg;

endmodule
`default_nettype wire
